@@ hw/rtl/itfmt_pkg.sv @@
// Shared types, constants and digit character function of the integer formatter.
`default_nettype none

package itfmt_pkg;

  localparam int NUM_BITS    = 64;
  localparam int MAX_WIDTH   = 63;
  localparam int DIGIT_SLOTS = 24;
  localparam int DEC_DIGITS  = 20;
  localparam int OCT_DIGITS  = 22;
  localparam int HEX_DIGITS  = 16;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef struct packed {
    logic [NUM_BITS-1:0] number;
    logic                signed_mode;
    logic [1:0]          radix_sel;
    logic                upper_digits;
    logic                show_sign;
    logic                sign_space;
    logic                align_left;
    logic                radix_prefix;
    logic                zero_pad;
    logic [5:0]          field_width;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } out_beat_t;

  typedef logic [DIGIT_SLOTS-1:0][3:0] digit_vec_t;

  // One converted number with everything the emitter needs.
  typedef struct packed {
    digit_vec_t digits;
    logic [4:0] ndig;
    logic       has_sign;
    logic [7:0] sign_char;
    logic [1:0] npfx;
    logic       upper;
    logic       left;
    logic       zpad;
    logic [5:0] pad;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + 8'(d);
    end else if (up) begin
      c = CH_A_UP + 8'(d) - 8'd10;
    end else begin
      c = CH_A_LO + 8'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itfmt_front.sv @@
// Front end: takes a number, builds its digit string and formatting command.
`default_nettype none

module itfmt_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire itfmt_pkg::in_beat_t in_beat,
  output logic                     q_push,
  input  wire logic                q_full,
  output itfmt_pkg::cmd_t          q_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  localparam logic [1:0] RADIX_SEL_OCT = itfmt_pkg::RADIX_OCT;
  localparam logic [1:0] RADIX_SEL_HEX = itfmt_pkg::RADIX_HEX;

  localparam int BCD_BITS = itfmt_pkg::DEC_DIGITS * 4;
  localparam int PAD_BITS = (itfmt_pkg::DIGIT_SLOTS - itfmt_pkg::DEC_DIGITS) * 4;
  localparam int OCT_BITS = itfmt_pkg::OCT_DIGITS * 3;

  logic [1:0]                     state_r, state_nxt;
  itfmt_pkg::in_beat_t            opt_r, opt_nxt;
  logic                           negative_r, negative_nxt;
  logic                           nonzero_r, nonzero_nxt;
  logic [itfmt_pkg::NUM_BITS-1:0] bin_r, bin_nxt;
  itfmt_pkg::digit_vec_t          dig_r, dig_nxt;
  logic [5:0]                     cnt_r, cnt_nxt;

  logic                           accept;
  logic                           neg_in;
  logic [itfmt_pkg::NUM_BITS-1:0] mag;
  logic [OCT_BITS-1:0]            mag_oct;
  logic [BCD_BITS-1:0]            bcd_adj;
  logic [BCD_BITS-1:0]            bcd_shift;
  logic [4:0]                     ndig;
  logic [1:0]                     npfx;
  logic [5:0]                     body;
  logic [5:0]                     width;

  assign in_full = (state_r != S_IDLE);
  assign accept  = in_push && !in_full;
  assign neg_in  = in_beat.signed_mode && in_beat.number[itfmt_pkg::NUM_BITS-1];
  assign mag     = neg_in ? (~in_beat.number + 1'b1) : in_beat.number;
  assign mag_oct = OCT_BITS'(mag);

  // Double dabble: adjust every BCD digit, then shift one binary bit in.
  always_comb begin
    for (int i = 0; i < itfmt_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    bcd_shift = {bcd_adj[BCD_BITS-2:0], bin_r[itfmt_pkg::NUM_BITS-1]};
  end

  // Digit count, prefix length and padding for the command.
  always_comb begin
    ndig = 5'd1;
    for (int i = 0; i < itfmt_pkg::DIGIT_SLOTS; i++) begin
      if (dig_r[i] != 4'd0) begin
        ndig = 5'(i + 1);
      end
    end
    npfx = 2'd0;
    if (opt_r.radix_prefix && nonzero_r) begin
      unique case (opt_r.radix_sel)
        RADIX_SEL_OCT: npfx = 2'd1;
        RADIX_SEL_HEX: npfx = 2'd2;
        default:       npfx = 2'd0;
      endcase
    end
    body  = 6'(npfx) + 6'(ndig);
    width = (opt_r.field_width > 6'(itfmt_pkg::MAX_WIDTH)) ?
            6'(itfmt_pkg::MAX_WIDTH) : opt_r.field_width;
  end

  always_comb begin
    q_data.digits    = dig_r;
    q_data.ndig      = ndig;
    q_data.has_sign  = negative_r || opt_r.show_sign;
    q_data.sign_char = negative_r ? itfmt_pkg::CH_MINUS :
                       (opt_r.sign_space ? itfmt_pkg::CH_SPACE : itfmt_pkg::CH_PLUS);
    q_data.npfx      = npfx;
    q_data.upper     = opt_r.upper_digits;
    q_data.left      = opt_r.align_left;
    q_data.zpad      = opt_r.zero_pad;
    q_data.pad       = (width > body) ? width - body : 6'd0;
  end

  assign q_push = (state_r == S_PUSH) && !q_full;

  always_comb begin
    state_nxt    = state_r;
    opt_nxt      = opt_r;
    negative_nxt = negative_r;
    nonzero_nxt  = nonzero_r;
    bin_nxt      = bin_r;
    dig_nxt      = dig_r;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          opt_nxt      = in_beat;
          negative_nxt = neg_in;
          nonzero_nxt  = (in_beat.number != '0);
          bin_nxt      = mag;
          cnt_nxt      = 6'd0;
          dig_nxt      = '0;
          unique case (in_beat.radix_sel)
            RADIX_SEL_OCT: begin
              for (int i = 0; i < itfmt_pkg::OCT_DIGITS; i++) begin
                dig_nxt[i] = {1'b0, mag_oct[3*i +: 3]};
              end
              state_nxt = S_PUSH;
            end
            RADIX_SEL_HEX: begin
              for (int i = 0; i < itfmt_pkg::HEX_DIGITS; i++) begin
                dig_nxt[i] = mag[4*i +: 4];
              end
              state_nxt = S_PUSH;
            end
            default: begin
              // Decimal, and the unused selector code, go through conversion.
              state_nxt = S_CONV;
            end
          endcase
        end
      end
      S_CONV: begin
        dig_nxt = itfmt_pkg::digit_vec_t'({{PAD_BITS{1'b0}}, bcd_shift});
        bin_nxt = {bin_r[itfmt_pkg::NUM_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(itfmt_pkg::NUM_BITS - 1)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    opt_r      <= opt_nxt;
    negative_r <= negative_nxt;
    nonzero_r  <= nonzero_nxt;
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/itfmt_fifo.sv @@
// Short command queue between the converter and the byte emitter.
`default_nettype none

module itfmt_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itfmt_pkg::cmd_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output itfmt_pkg::cmd_t      pop_data,
  output logic                 empty
);

  localparam int PTR_W = (itfmt_pkg::FIFO_DEPTH > 1) ? $clog2(itfmt_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(itfmt_pkg::FIFO_DEPTH + 1);

  itfmt_pkg::cmd_t  mem_r [itfmt_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(itfmt_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(itfmt_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(itfmt_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/itfmt_back.sv @@
// Back end: walks the sections of a formatted number, a byte per unstalled cycle.
`default_nettype none

module itfmt_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire itfmt_pkg::cmd_t      q_data,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output itfmt_pkg::out_beat_t      out_beat
);

  // Sections in output order; empty ones are skipped.
  localparam logic [2:0] P_SIGN = 3'd0;
  localparam logic [2:0] P_LPAD = 3'd1;
  localparam logic [2:0] P_PFX0 = 3'd2;
  localparam logic [2:0] P_PFXX = 3'd3;
  localparam logic [2:0] P_ZPAD = 3'd4;
  localparam logic [2:0] P_DIG  = 3'd5;
  localparam logic [2:0] P_RPAD = 3'd6;
  localparam int         NUM_PHASES = 7;

  function automatic logic [5:0] phase_len(input itfmt_pkg::cmd_t c, input logic [2:0] p);
    logic [5:0] len;
    unique case (p)
      P_SIGN:  len = 6'(c.has_sign);
      P_LPAD:  len = (!c.left && !c.zpad) ? c.pad : 6'd0;
      P_PFX0:  len = (c.npfx != 2'd0) ? 6'd1 : 6'd0;
      P_PFXX:  len = (c.npfx == 2'd2) ? 6'd1 : 6'd0;
      P_ZPAD:  len = (!c.left && c.zpad) ? c.pad : 6'd0;
      P_DIG:   len = 6'(c.ndig);
      P_RPAD:  len = c.left ? c.pad : 6'd0;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] first_from(input itfmt_pkg::cmd_t c, input logic [3:0] from);
    logic [2:0] ph;
    logic       found;
    ph    = P_RPAD;
    found = 1'b0;
    for (int k = 0; k < NUM_PHASES; k++) begin
      if (!found && (4'(k) >= from) && (phase_len(c, 3'(k)) != 6'd0)) begin
        ph    = 3'(k);
        found = 1'b1;
      end
    end
    return ph;
  endfunction

  logic                 busy_r, busy_nxt;
  itfmt_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [2:0]           phase_r, phase_nxt;
  logic [5:0]           rem_r, rem_nxt;
  logic [6:0]           tot_r, tot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  itfmt_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic                 emit;
  logic [2:0]           load_phase;
  logic [2:0]           step_phase;
  logic [4:0]           dig_idx;
  logic [7:0]           cur_char;

  assign q_pop      = !busy_r && !q_empty;
  assign emit       = busy_r && (!out_valid_r || out_pop);
  assign load_phase = first_from(q_data, 4'd0);
  assign step_phase = first_from(cmd_r, {1'b0, phase_r} + 4'd1);
  assign dig_idx    = 5'(rem_r - 6'd1);
  assign out_empty  = !out_valid_r;
  assign out_beat   = out_beat_r;

  always_comb begin
    unique case (phase_r) inside
      P_SIGN:         cur_char = cmd_r.sign_char;
      P_LPAD, P_RPAD: cur_char = itfmt_pkg::CH_SPACE;
      P_PFX0, P_ZPAD: cur_char = itfmt_pkg::CH_ZERO;
      P_PFXX:         cur_char = cmd_r.upper ? itfmt_pkg::CH_X_UP : itfmt_pkg::CH_X_LO;
      P_DIG:          cur_char = itfmt_pkg::digit_char(cmd_r.digits[dig_idx], cmd_r.upper);
      default:        cur_char = itfmt_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    tot_nxt       = tot_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt  = 1'b1;
      cmd_nxt   = q_data;
      phase_nxt = load_phase;
      rem_nxt   = phase_len(q_data, load_phase);
      tot_nxt   = 7'(q_data.has_sign) + 7'(q_data.pad) + 7'(q_data.npfx) + 7'(q_data.ndig);
    end
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_beat_nxt.text_byte  = cur_char;
      out_beat_nxt.final_byte = (tot_r == 7'd1);
      tot_nxt                 = tot_r - 7'd1;
      if (tot_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
      if (rem_r == 6'd1) begin
        phase_nxt = step_phase;
        rem_nxt   = phase_len(cmd_r, step_phase);
      end else begin
        rem_nxt = rem_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    phase_r    <= phase_nxt;
    rem_r      <= rem_nxt;
    tot_r      <= tot_nxt;
    out_beat_r <= out_beat_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter_top.sv @@
// Top level of the printf-style integer to ASCII formatter.
`default_nettype none

// Each input beat carries one 64-bit number and its printf-style options; the
// block answers with the formatted text, one ASCII character per output beat,
// and sets final_byte on the last character of that number. Every number gives
// at least one beat and at most 64. The front end converts the number: a
// decimal conversion runs a double-dabble loop that shifts in one binary bit
// per cycle, and the input side takes no new number until the result has been
// handed over; octal and hex digits are bit slices and go straight from the
// accept to the hand-over, which waits while the command queue is full.
// A two-entry command queue sits between the converter and the emitter, so the
// next number is taken and converted while the previous one is still being
// written out. The emitter loads a command and then produces one character per
// cycle while the output side keeps popping. Sustained throughput is therefore
// set by the slower of the conversion and the character output.
// The oldest character waits in an output register, so a stalled reader never
// stops the conversion of later numbers until the queue fills.
module integer_to_ascii_formatter_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire itfmt_pkg::in_beat_t  in_beat,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output itfmt_pkg::out_beat_t      out_beat
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  itfmt_pkg::cmd_t q_wdata;
  itfmt_pkg::cmd_t q_rdata;

  // Converter: magnitude, digits, prefix and padding for each number.
  itfmt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_beat (in_beat),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  // Decouples conversion from character output.
  itfmt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Emitter: sign, padding, prefix and digits in printf order.
  itfmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

@@ tb/integer_to_ascii_formatter_top_tb.sv @@
// Self-checking testbench for the integer to ASCII formatter top level.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_top_tb;
  import itfmt_pkg::*;

  // The package names octal and hex only. Decimal is selector zero, and
  // selector three falls back to decimal as well.
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_ALT = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned MAX_REPORTS  = 10;

  // The reader holds off completely for this window of its own cycles, which
  // falls while the sender is still busy, so the command queue fills up and
  // the input side has to stall.
  localparam int unsigned HOLD_START = 1500;
  localparam int unsigned HOLD_LEN   = 800;

  // A decimal number converts one bit at a time and the longest text is 64
  // characters; the drain window is sized to cover anything in flight.
  localparam int unsigned DRAIN_CYCLES = 200;

  // Slowest correct run: about 275 numbers, each converted bit by bit and
  // written out as up to 64 characters to the slowest reader, plus sender
  // gaps and the long hold-off. The limit leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    in_beat_t beat;
    string    text;   // empty: the expectation comes from the predictor
  } directed_row_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  in_beat_t  in_beat = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_beat_t out_beat;

  // Characters still owed by the block, oldest first.
  out_beat_t   expected_text_q[$];
  int unsigned error_count = 0;
  int unsigned rx_cycles   = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 1;

  integer_to_ascii_formatter_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_beat  (in_beat),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_beat (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_beat_t fmt(input logic [63:0] number, input logic sgn,
                                   input logic [1:0] radix,
                                   input logic up, show, space, left, pfx, zpad,
                                   input logic [5:0] width);
    in_beat_t b;
    b.number       = number;
    b.signed_mode  = sgn;
    b.radix_sel    = radix;
    b.upper_digits = up;
    b.show_sign    = show;
    b.sign_space   = space;
    b.align_left   = left;
    b.radix_prefix = pfx;
    b.zero_pad     = zpad;
    b.field_width  = width;
    return b;
  endfunction

  // Queue a run of characters, the last one carrying the final flag.
  function automatic void expect_text(input logic [7:0] txt[$]);
    out_beat_t c;
    for (int k = 0; k < txt.size(); k++) begin
      c.text_byte  = txt[k];
      c.final_byte = (k == txt.size() - 1);
      expected_text_q.push_back(c);
    end
  endfunction

  // Works out the text for one number: sign, then prefix, padding and digits
  // in the order that the alignment and pad options call for.
  function automatic void format_number(input in_beat_t b);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  d;
    logic [7:0]  dig[DIGIT_SLOTS];
    logic [7:0]  txt[$];
    int unsigned ndig;
    int unsigned npfx;
    int unsigned body;
    int unsigned width;
    int unsigned pad;
    logic        neg;
    mag  = b.number;
    neg  = 1'b0;
    ndig = 0;
    npfx = 0;
    pad  = 0;
    if (b.signed_mode && mag[63]) begin
      neg = 1'b1;
      mag = 64'd0 - mag;
    end
    case (b.radix_sel)
      RADIX_OCT: base = 64'd8;
      RADIX_HEX: base = 64'd16;
      default:   base = 64'd10;
    endcase
    // A zero value never gets a prefix.
    if (b.radix_prefix && mag != 0) begin
      if (b.radix_sel == RADIX_OCT) begin
        npfx = 1;
      end else if (b.radix_sel == RADIX_HEX) begin
        npfx = 2;
      end
    end
    if (mag == 0) begin
      dig[0] = CH_ZERO;
      ndig   = 1;
    end else begin
      while (mag != 0 && ndig < DIGIT_SLOTS) begin
        d = 4'(mag % base);
        if (d < 4'd10) begin
          dig[ndig] = CH_ZERO + 8'(d);
        end else begin
          dig[ndig] = (b.upper_digits ? CH_A_UP : CH_A_LO) + 8'(d) - 8'd10;
        end
        ndig++;
        mag = mag / base;
      end
    end
    width = b.field_width;
    if (width > MAX_WIDTH) begin
      width = MAX_WIDTH;
    end
    body = npfx + ndig;
    if (width > body) begin
      pad = width - body;
    end
    if (neg) begin
      txt.push_back(CH_MINUS);
    end else if (b.show_sign) begin
      txt.push_back(b.sign_space ? CH_SPACE : CH_PLUS);
    end
    if (!b.align_left && !b.zero_pad) begin
      repeat (pad) txt.push_back(CH_SPACE);
    end
    if (npfx >= 1) begin
      txt.push_back(CH_ZERO);
    end
    if (npfx == 2) begin
      txt.push_back(b.upper_digits ? CH_X_UP : CH_X_LO);
    end
    if (!b.align_left && b.zero_pad) begin
      repeat (pad) txt.push_back(CH_ZERO);
    end
    for (int i = ndig; i > 0; i--) begin
      txt.push_back(dig[i - 1]);
    end
    if (b.align_left) begin
      repeat (pad) txt.push_back(CH_SPACE);
    end
    expect_text(txt);
  endfunction

  // Random numbers lean toward small values, short bit lengths and the
  // extremes, since those are where sign, padding and prefix interact. Most
  // widths are small so that decimal conversion dominates the run time.
  function automatic in_beat_t random_beat();
    logic [95:0] noise;
    logic [63:0] full;
    in_beat_t    b;
    noise = {$urandom, $urandom, $urandom};
    full  = {$urandom, $urandom};
    b     = noise[$bits(in_beat_t)-1:0];
    case ($urandom_range(0, 7))
      0: b.number = 64'($urandom_range(0, 20));
      1: b.number = 64'd0 - 64'($urandom_range(1, 1000));
      2: begin
        case ($urandom_range(0, 4))
          0:       b.number = 64'd0;
          1:       b.number = 64'd1;
          2:       b.number = ALL_ONES;
          3:       b.number = MOST_NEG;
          default: b.number = MOST_POS;
        endcase
      end
      3, 4:    b.number = full >> $urandom_range(0, 63);
      default: b.number = full;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      b.field_width = 6'($urandom_range(0, 63));
    end else begin
      b.field_width = 6'($urandom_range(0, 24));
    end
    return b;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Offers one beat until the block takes it, records what it must answer,
  // then decides whether the sender's burst goes on or a gap follows. During
  // a gap the payload wiggles so that the block is seen to ignore it.
  task automatic offer(input in_beat_t b, input string typed);
    logic [7:0]  txt[$];
    logic [95:0] noise;
    int unsigned gap;
    in_push <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_full !== 1'b0);
    if (typed.len() == 0) begin
      format_number(b);
    end else begin
      for (int k = 0; k < typed.len(); k++) begin
        txt.push_back(typed[k]);
      end
      expect_text(txt);
    end
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        noise    = {$urandom, $urandom, $urandom};
        in_push <= 1'b0;
        in_beat <= noise[$bits(in_beat_t)-1:0];
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result side: check the beat taken at this edge, then pick the next pop.
  // The reader cycles through steady popping, coin flips, sparse periodic pops
  // and rare stalls, with one long hold-off to back up the whole pipeline.
  always @(posedge clk) begin : result_side
    out_beat_t want;
    if (out_pop && !out_empty) begin
      if (expected_text_q.size() == 0) begin
        note_error($sformatf("unexpected character %h final %b",
                             out_beat.text_byte, out_beat.final_byte));
      end else begin
        want = expected_text_q.pop_front();
        if (out_beat.text_byte !== want.text_byte ||
            out_beat.final_byte !== want.final_byte) begin
          note_error($sformatf("character mismatch: expected %h final %b, got %h final %b",
                               want.text_byte, want.final_byte,
                               out_beat.text_byte, out_beat.final_byte));
        end
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
        out_pop <= 1'b0;
      end else begin
        case ((rx_cycles / 200) % 4)
          0:       out_pop <= 1'b1;
          1:       out_pop <= 1'($urandom_range(0, 1));
          2:       out_pop <= (rx_cycles % 3 == 0);
          default: out_pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t rows[$];

    // Columns: number, signed, radix, upper, show sign, sign space, left,
    // prefix, zero pad, width. Extremes and error-free corner cases carry
    // their text; the wide and mixed rows go through the predictor.
    rows.push_back('{fmt(64'd0,    0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 6'd0), "0"});
    rows.push_back('{fmt(ALL_ONES, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 6'd0),
                     "18446744073709551615"});
    rows.push_back('{fmt(ALL_ONES, 1, RADIX_DEC, 0, 0, 0, 0, 0, 0, 6'd0), "-1"});
    rows.push_back('{fmt(MOST_NEG, 1, RADIX_DEC, 0, 0, 0, 0, 0, 0, 6'd0),
                     "-9223372036854775808"});
    rows.push_back('{fmt(MOST_POS, 1, RADIX_DEC, 0, 1, 0, 0, 0, 0, 6'd0),
                     "+9223372036854775807"});
    rows.push_back('{fmt(64'd5,    0, RADIX_DEC, 0, 1, 1, 0, 0, 0, 6'd0), " 5"});
    rows.push_back('{fmt(MOST_NEG, 0, RADIX_OCT, 0, 0, 0, 0, 1, 0, 6'd0),
                     "01000000000000000000000"});
    rows.push_back('{fmt(ALL_ONES, 0, RADIX_HEX, 1, 0, 0, 0, 1, 0, 6'd0),
                     "0XFFFFFFFFFFFFFFFF"});
    rows.push_back('{fmt(ALL_ONES, 0, RADIX_HEX, 0, 0, 0, 0, 1, 0, 6'd0),
                     "0xffffffffffffffff"});
    // A zero value drops the prefix in both octal and hex.
    rows.push_back('{fmt(64'd0,    0, RADIX_HEX, 0, 0, 0, 0, 1, 0, 6'd0), "0"});
    rows.push_back('{fmt(64'd0,    0, RADIX_OCT, 0, 0, 0, 0, 1, 0, 6'd0), "0"});
    rows.push_back('{fmt(64'd255,  0, RADIX_ALT, 1, 0, 0, 0, 1, 0, 6'd0), "255"});
    rows.push_back('{fmt(64'hABCDEF, 0, RADIX_HEX, 1, 0, 0, 0, 0, 0, 6'd0), "ABCDEF"});
    // The sign sits outside the field width.
    rows.push_back('{fmt(64'd0 - 64'd42, 1, RADIX_DEC, 0, 0, 0, 0, 0, 1, 6'd6),
                     "-000042"});
    rows.push_back('{fmt(64'h1F,   0, RADIX_HEX, 0, 0, 0, 0, 1, 1, 6'd8), "0x00001f"});
    rows.push_back('{fmt(64'd7,    0, RADIX_DEC, 0, 0, 0, 1, 0, 0, 6'd5), "7    "});
    rows.push_back('{fmt(64'd7,    0, RADIX_DEC, 0, 1, 0, 0, 0, 0, 6'd5), "+    7"});
    rows.push_back('{fmt(64'd0,    1, RADIX_DEC, 0, 1, 1, 0, 0, 0, 6'd0), " 0"});
    rows.push_back('{fmt(ALL_ONES, 1, RADIX_HEX, 0, 0, 0, 0, 1, 0, 6'd0), "-0x1"});
    rows.push_back('{fmt(64'd0,    0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 6'd63), ""});
    rows.push_back('{fmt(ALL_ONES, 1, RADIX_HEX, 1, 1, 0, 1, 1, 1, 6'd63), ""});
    rows.push_back('{fmt(MOST_NEG, 1, RADIX_OCT, 0, 1, 1, 0, 1, 1, 6'd63), ""});
    rows.push_back('{fmt(ALL_ONES, 0, RADIX_OCT, 0, 0, 0, 0, 1, 1, 6'd40), ""});
    rows.push_back('{fmt(64'd123,  1, RADIX_DEC, 0, 1, 1, 1, 0, 1, 6'd10), ""});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      offer(rows[i].beat, rows[i].text);
    end
    repeat (RANDOM_ITEMS) begin
      offer(random_beat(), "");
    end
    in_push <= 1'b0;

    // Everything is in; wait for the block to finish answering, then leave
    // room for any stray beat that should not be there.
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
